>>> rtl/ipid_pkg.sv
// ipid_pkg: transaction payload types, register indexes and constants of the pid step
// shared by the serial multiplier, the top level and the checker; no dependencies

package ipid_pkg;

    // transaction payloads
    typedef struct packed {
        logic               mode;
        logic signed [15:0] error_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } t_out;

    // input modes
    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_TS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [15:0] KP_RESET    = 16'd256;
    localparam logic [14:0] LIMIT_RESET = 15'd32767;

    // filter coefficient 0.005 in q0.16 and integral clamp of 5.0 in q8.8
    localparam logic [8:0]  LPF_COEF    = 9'd328;
    localparam logic [11:0] INTEG_CLAMP = 12'd1280;

    // serial multiplier geometry
    localparam int MC_W   = 43;            // signed multiplicand
    localparam int MP_W   = 24;            // unsigned multiplier, one bit per cycle
    localparam int PROD_W = MC_W + MP_W;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] STEPS_P = 5'd16;
    localparam logic [STEP_W-1:0] STEPS_I = 5'd16;
    localparam logic [STEP_W-1:0] STEPS_R = 5'd24;
    localparam logic [STEP_W-1:0] STEPS_F = 5'd9;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_mul_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

>>> rtl/ipid_mul.sv
// ipid_mul: shift-add multiplier, signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, lsb first; depends on ipid_pkg

module ipid_mul
    import ipid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_ctrl                i_ctrl,
    input  logic [MC_W-1:0]          i_mcand,
    input  logic [MP_W-1:0]          i_mplier,
    output t_mul_stat                o_stat,
    output logic [PROD_W-1:0]        o_prod
);

    logic [PROD_W-1:0] r_prod;
    logic [MC_W-1:0]   r_mcand;
    logic [STEP_W-1:0] r_count;
    logic              r_busy;
    logic              r_done;

    logic [MC_W:0]     w_hi;
    logic [MC_W:0]     w_add;
    logic [MC_W:0]     w_sum;

    // partial product lands on the high half, then everything moves right
    assign w_hi  = {r_prod[PROD_W-1], r_prod[PROD_W-1:MP_W]};
    assign w_add = r_prod[0] ? {r_mcand[MC_W-1], r_mcand} : '0;
    assign w_sum = w_hi + w_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_prod  <= {{MC_W{1'b0}}, i_mplier};
                r_mcand <= i_mcand;
                r_count <= i_ctrl.steps;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_prod  <= {w_sum, r_prod[MP_W-1:1]};
                r_count <= r_count - 1'b1;
                if (r_count == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_prod;

endmodule

>>> rtl/incremental_pid_controller_top.sv
// incremental_pid_controller_top: velocity-form pid step with sequencer and datapath
// uses ipid_pkg for payload types and constants, and ipid_mul for every product
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | to block  | i_in_valid/o_in_stall | i_in_data   (t_in)
//  out     | from block| o_out_valid/i_out_stall| o_out_data (t_out)
//  cfg     | to block  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// a control transaction runs its four products (kp, ki*ts, kd/ts, filter
// coefficient) one after another through the single shift-add unit, each for
// the bit steps set in ipid_pkg, with sequencing states around them (a start
// and a wait state per product, filter update, two sum steps, saturation and
// hand-off); after the hand-off the block is idle and takes the next transaction
// a clear transaction goes from idle straight to the hand-off state
// one transaction is in work at a time; the result register lets the next
// transaction be accepted while the previous result still waits downstream;
// a finished result meeting a full, stalled result register holds o_in_stall high
// reset is synchronous and active low; registers return to their reset values
// and the history is zeroed; cfg writes are always taken (o_cfg_ready stays high)

module incremental_pid_controller_top
    import ipid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    // result transactions
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_GO,  S_P_WAIT,
        S_I_GO,  S_I_WAIT,
        S_R_GO,  S_R_WAIT,
        S_F_GO,  S_F_WAIT,
        S_F_ADD,
        S_SUM1,  S_SUM2,
        S_SAT,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0] r_kp;
    logic [15:0] r_ki;
    logic [23:0] r_kd;
    logic [14:0] r_lim;

    // controller history
    logic [15:0] r_ep;      // previous error
    logic [15:0] r_ep2;     // error before that
    logic [15:0] r_dp;      // previous saturated drive
    logic [31:0] r_df;      // filtered derivative, q16.16

    // working registers for the transaction in flight
    logic [15:0] r_e;
    logic [25:0] r_p;
    logic [11:0] r_i;
    logic [42:0] r_diff;
    logic [36:0] r_t;
    logic [27:0] r_acc;
    t_out        r_res;

    // result register
    logic        r_out_valid;
    t_out        r_out;

    // multiplier hookup
    t_mul_ctrl         w_mul_ctrl;
    t_mul_stat         w_mul_stat;
    logic [MC_W-1:0]   w_mcand;
    logic [MP_W-1:0]   w_mplier;
    logic [PROD_W-1:0] w_prod;

    // datapath terms
    logic [16:0] w_d1;      // e - e1
    logic [17:0] w_dd;      // e - 2*e1 + e2
    logic [33:0] w_p_rnd;
    logic [32:0] w_i_rnd;
    logic [16:0] w_i_raw;
    logic [11:0] w_i_clamp;
    logic [42:0] w_raw_diff;
    logic [52:0] w_t_rnd;
    logic [37:0] w_df_sum;
    logic [31:0] w_df_sat;
    logic [32:0] w_d_rnd;
    logic [27:0] w_lim;
    logic [27:0] w_sum1;
    logic [27:0] w_sum2;
    logic        w_in_take;
    logic        w_out_free;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // differences of the error history
    assign w_d1 = {r_e[15], r_e} - {r_ep[15], r_ep};
    assign w_dd = {{2{r_e[15]}}, r_e} - {r_ep[15], r_ep, 1'b0} + {{2{r_ep2[15]}}, r_ep2};

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_ctrl.start = 1'b0;
        w_mul_ctrl.steps = STEPS_P;
        w_mcand          = {{26{w_d1[16]}}, w_d1};
        w_mplier         = {8'd0, r_kp};
        unique case (r_state)
            S_P_GO: begin
                w_mul_ctrl.start = 1'b1;
            end
            S_I_GO: begin
                w_mul_ctrl.start = 1'b1;
                w_mul_ctrl.steps = STEPS_I;
                w_mcand          = {{27{r_e[15]}}, r_e};
                w_mplier         = {8'd0, r_ki};
            end
            S_R_GO: begin
                w_mul_ctrl.start = 1'b1;
                w_mul_ctrl.steps = STEPS_R;
                w_mcand          = {{25{w_dd[17]}}, w_dd};
                w_mplier         = r_kd;
            end
            S_F_GO: begin
                w_mul_ctrl.start = 1'b1;
                w_mul_ctrl.steps = STEPS_F;
                w_mcand          = r_diff;
                w_mplier         = {15'd0, LPF_COEF};
            end
            default: begin
            end
        endcase
    end

    ipid_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mul_ctrl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_stat   (w_mul_stat),
        .o_prod   (w_prod)
    );

    // product extraction: after n steps the product sits at the top, ending at bit 24-n
    // proportional term, round half up by 2^8
    assign w_p_rnd = {w_prod[40], w_prod[40:8]} + 34'd128;

    // integral term, round by 2^16 then clamp to +/- 5.0
    assign w_i_rnd = {w_prod[39], w_prod[39:8]} + 33'h0_8000;
    assign w_i_raw = w_i_rnd[32:16];
    always_comb begin
        if ($signed(w_i_raw) > $signed({5'd0, INTEG_CLAMP})) begin
            w_i_clamp = INTEG_CLAMP;
        end else if ($signed(w_i_raw) < -$signed({5'd0, INTEG_CLAMP})) begin
            w_i_clamp = -INTEG_CLAMP;
        end else begin
            w_i_clamp = w_i_raw[11:0];
        end
    end

    // raw derivative minus its filtered value, feeds the filter product
    assign w_raw_diff = {w_prod[41], w_prod[41:0]} - {{11{r_df[31]}}, r_df};

    // filter increment, round by 2^16
    assign w_t_rnd = {w_prod[66], w_prod[66:15]} + 53'h8000;

    // filter update saturates to the 32-bit signed range
    assign w_df_sum = {{6{r_df[31]}}, r_df} + {r_t[36], r_t};
    always_comb begin
        if (w_df_sum[37:31] == 7'h00 || w_df_sum[37:31] == 7'h7f) begin
            w_df_sat = w_df_sum[31:0];
        end else if (w_df_sum[37]) begin
            w_df_sat = 32'h8000_0000;
        end else begin
            w_df_sat = 32'h7fff_ffff;
        end
    end

    // derivative term in q8.8
    assign w_d_rnd = {r_df[31], r_df} + 33'd128;

    // drive sum
    assign w_sum1 = {{12{r_dp[15]}}, r_dp} + {{2{r_p[25]}}, r_p} + {{16{r_i[11]}}, r_i};
    assign w_sum2 = r_acc + {{3{w_d_rnd[32]}}, w_d_rnd[32:8]};
    assign w_lim  = {13'd0, r_lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= KP_RESET;
            r_ki        <= '0;
            r_kd        <= '0;
            r_lim       <= LIMIT_RESET;
            r_ep        <= '0;
            r_ep2       <= '0;
            r_dp        <= '0;
            r_df        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes; the user must issue them only while idle, the block does not enforce it
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KP:    r_kp  <= i_cfg_data[15:0];
                    CFG_KI_TS: r_ki  <= i_cfg_data[15:0];
                    CFG_KD_TS: r_kd  <= i_cfg_data;
                    CFG_LIMIT: r_lim <= i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end

            // result register empties when the downstream side takes it
            // and no new result is handed over in the same cycle
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        if (i_in_data.mode == MODE_CLEAR) begin
                            // clear zeroes history and answers with zero drive
                            r_ep    <= '0;
                            r_ep2   <= '0;
                            r_dp    <= '0;
                            r_df    <= '0;
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_e     <= i_in_data.error_value;
                            r_state <= S_P_GO;
                        end
                    end
                end
                S_P_GO: r_state <= S_P_WAIT;
                S_P_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_p     <= w_p_rnd[33:8];
                        r_state <= S_I_GO;
                    end
                end
                S_I_GO: r_state <= S_I_WAIT;
                S_I_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_i     <= w_i_clamp;
                        r_state <= S_R_GO;
                    end
                end
                S_R_GO: r_state <= S_R_WAIT;
                S_R_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_diff  <= w_raw_diff;
                        r_state <= S_F_GO;
                    end
                end
                S_F_GO: r_state <= S_F_WAIT;
                S_F_WAIT: begin
                    if (w_mul_stat.done) begin
                        r_t     <= w_t_rnd[52:16];
                        r_state <= S_F_ADD;
                    end
                end
                S_F_ADD: begin
                    r_df    <= w_df_sat;
                    r_state <= S_SUM1;
                end
                S_SUM1: begin
                    r_acc   <= w_sum1;
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_acc   <= w_sum2;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // clamp to +/- limit; a zero limit forces zero drive
                    if ($signed(r_acc) > $signed(w_lim)) begin
                        r_res.drive     <= w_lim[15:0];
                        r_res.saturated <= 1'b1;
                        r_dp            <= w_lim[15:0];
                    end else if ($signed(r_acc) < -$signed(w_lim)) begin
                        r_res.drive     <= -w_lim[15:0];
                        r_res.saturated <= 1'b1;
                        r_dp            <= -w_lim[15:0];
                    end else begin
                        r_res.drive     <= r_acc[15:0];
                        r_res.saturated <= 1'b0;
                        r_dp            <= r_acc[15:0];
                    end
                    r_ep2   <= r_ep;
                    r_ep    <= r_e;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/ipid_chk.sv
// ipid_chk: port-level checks on the pid step top level, attached by bind
// depends on ipid_pkg and on the port list of incremental_pid_controller_top

module ipid_chk
    import ipid_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in                   i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out                  o_out_data,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted while busy");

    // a result only appears after a transaction has been in work
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a transaction in work");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind incremental_pid_controller_top ipid_chk u_ipid_chk (.*);
